// ===== rtl/udr_pkg.sv =====
// Shared definitions for the unsigned divide/remainder unit.
// Holds the default operand width and the control bundle passed between
// pipeline stages. Has no dependencies.
`default_nettype none

package udr_pkg;

    localparam int WIDTH_DEF = 63;

    // Control that travels alongside each division through the pipeline.
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

endpackage

`default_nettype wire

// ===== rtl/udr_stage.sv =====
// One restoring-division step with its output registers.
// Produces one quotient bit per stage; uses t_ctl from udr_pkg.
`default_nettype none

module udr_stage #(
    parameter int WIDTH = udr_pkg::WIDTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  udr_pkg::t_ctl     i_ctl,
    input  wire [WIDTH-1:0]   i_rem,
    input  wire [WIDTH-1:0]   i_quo,
    input  wire [WIDTH-1:0]   i_dvs,
    output udr_pkg::t_ctl     o_ctl,
    output logic [WIDTH-1:0]  o_rem,
    output logic [WIDTH-1:0]  o_quo,
    output logic [WIDTH-1:0]  o_dvs
);
    import udr_pkg::*;

    logic [WIDTH:0]   trial;
    logic             take;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_quo;
    t_ctl             r_ctl;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_dvs;

    // The quotient register starts out holding the dividend; its top bit is
    // shifted into the partial remainder while the new quotient bit enters
    // at the bottom. A zero divisor never subtracts, so after all steps the
    // quotient is zero and the remainder has collected the whole dividend.
    always_comb begin
        trial = {i_rem, i_quo[WIDTH-1]} - {1'b0, i_dvs};
        take  = !trial[WIDTH] && !i_ctl.zero;
        if (take) begin
            n_rem = trial[WIDTH-1:0];
        end else begin
            n_rem = {i_rem[WIDTH-2:0], i_quo[WIDTH-1]};
        end
        n_quo = {i_quo[WIDTH-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_dvs <= i_dvs;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_dvs = r_dvs;

endmodule

`default_nettype wire

// ===== rtl/unsigned_divide_remainder_unit.sv =====
// A division passes through one stage per quotient bit, then the output register,
// on its way from input transfer to o_out_valid. Throughput: one division per cycle
// while o_in_ready is high. The pipeline stalls only when both the output register
// and the skid register are occupied; o_in_ready is low exactly then.
// Reset (synchronous, active low) empties every stage and both output registers.
// Depends on udr_pkg and udr_stage.
`default_nettype none

module unsigned_divide_remainder_unit #(
    parameter int WIDTH = udr_pkg::WIDTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire [WIDTH-1:0]   i_dividend,
    input  wire [WIDTH-1:0]   i_divisor,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [WIDTH-1:0]  o_quotient,
    output logic [WIDTH-1:0]  o_remainder,
    output logic              o_zero_divisor
);
    import udr_pkg::*;

    t_ctl             s_ctl [0:WIDTH];
    logic [WIDTH-1:0] s_rem [0:WIDTH];
    logic [WIDTH-1:0] s_quo [0:WIDTH];
    logic [WIDTH-1:0] s_dvs [0:WIDTH];
    logic             adv;

    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_quo;
    logic [WIDTH-1:0] r_out_rem;
    logic             r_out_zero;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_skid_quo;
    logic [WIDTH-1:0] r_skid_rem;
    logic             r_skid_zero;

    assign adv        = !r_skid_valid;
    assign o_in_ready = adv;

    always_comb begin
        s_ctl[0].valid = i_in_valid;
        s_ctl[0].zero  = (i_divisor == '0);
        s_rem[0]       = '0;
        s_quo[0]       = i_dividend;
        s_dvs[0]       = i_divisor;
    end

    for (genvar k = 0; k < WIDTH; k++) begin : g_stage
        udr_stage #(
            .WIDTH (WIDTH)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_ctl   (s_ctl[k]),
            .i_rem   (s_rem[k]),
            .i_quo   (s_quo[k]),
            .i_dvs   (s_dvs[k]),
            .o_ctl   (s_ctl[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_quo   (s_quo[k+1]),
            .o_dvs   (s_dvs[k+1])
        );
    end

    // Output register with a skid register behind it. A result leaving the
    // last stage while the output is held goes to the skid, which then
    // freezes the pipeline until the output drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_out_ready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= s_ctl[WIDTH].valid;
        end else if (s_ctl[WIDTH].valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_out_ready) begin
                r_out_quo  <= r_skid_quo;
                r_out_rem  <= r_skid_rem;
                r_out_zero <= r_skid_zero;
            end
        end else if (!r_out_valid || i_out_ready) begin
            r_out_quo  <= s_quo[WIDTH];
            r_out_rem  <= s_rem[WIDTH];
            r_out_zero <= s_ctl[WIDTH].zero;
        end else begin
            r_skid_quo  <= s_quo[WIDTH];
            r_skid_rem  <= s_rem[WIDTH];
            r_skid_zero <= s_ctl[WIDTH].zero;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_quotient     = r_out_quo;
    assign o_remainder    = r_out_rem;
    assign o_zero_divisor = r_out_zero;

endmodule

`default_nettype wire

// ===== rtl/udr_checker.sv =====
// Port-level checks for unsigned_divide_remainder_unit, bound to the top level.
// Depends on udr_pkg for the default width.
`default_nettype none

module udr_checker #(
    parameter int WIDTH = udr_pkg::WIDTH_DEF
) (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_in_valid,
    input wire             o_in_ready,
    input wire [WIDTH-1:0] i_dividend,
    input wire [WIDTH-1:0] i_divisor,
    input wire             o_out_valid,
    input wire             i_out_ready,
    input wire [WIDTH-1:0] o_quotient,
    input wire [WIDTH-1:0] o_remainder,
    input wire             o_zero_divisor
);
    import udr_pkg::*;

    // A held result must not change before its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_quotient) && $stable(o_remainder)
            && $stable(o_zero_divisor))
        else $error("output changed while stalled");

    a_zero_quo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_divisor |-> o_quotient == '0)
        else $error("nonzero quotient for zero divisor");

    // Input back-pressure only arises with a result already waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not empty after reset");

endmodule

bind unsigned_divide_remainder_unit udr_checker #(
    .WIDTH (WIDTH)
) u_udr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_dividend     (i_dividend),
    .i_divisor      (i_divisor),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_quotient     (o_quotient),
    .o_remainder    (o_remainder),
    .o_zero_divisor (o_zero_divisor)
);

`default_nettype wire

// ===== tb/sv/unsigned_divide_remainder_unit_tb.sv =====
// Self-checking testbench for unsigned_divide_remainder_unit: directed and random
// divisions under several flow-control patterns, checked against an in-bench predictor.
// Depends on udr_pkg and the unit itself.
`default_nettype none

module unsigned_divide_remainder_unit_tb;

    import udr_pkg::*;

    localparam int W          = WIDTH_DEF;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = W + 20;

    typedef logic [W-1:0] t_operand;

    typedef struct packed {
        t_operand dividend;
        t_operand divisor;
    } t_div_operands;

    typedef struct packed {
        t_operand quotient;
        t_operand remainder;
        logic     zero_divisor;
    } t_div_result;

    typedef enum logic [2:0] {
        PH_DIRECTED,
        PH_STREAM,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_IDLE,
        PH_BACKPRESSURE
    } t_phase;

    localparam t_operand OP_MAX = {W{1'b1}};
    localparam t_operand OP_ONE = t_operand'(1);

    logic     i_clk          = 1'b0;
    logic     i_rst_n        = 1'b0;
    logic     i_in_valid     = 1'b0;
    t_operand i_dividend     = '0;
    t_operand i_divisor      = '0;
    logic     i_out_ready    = 1'b0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_operand o_quotient;
    t_operand o_remainder;
    logic     o_zero_divisor;

    t_phase        phase = PH_DIRECTED;
    t_div_operands pending_ops[$];
    t_div_result   expected_results[$];
    int            failures           = 0;
    int            ops_accepted       = 0;
    int            results_checked    = 0;
    int            zero_div_results   = 0;
    int            input_stall_cycles = 0;
    int            hold_cnt           = 0;

    unsigned_divide_remainder_unit #(
        .WIDTH(W)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_dividend     (i_dividend),
        .i_divisor      (i_divisor),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_quotient     (o_quotient),
        .o_remainder    (o_remainder),
        .o_zero_divisor (o_zero_divisor)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // A zero divisor yields quotient 0 with the dividend passed through as remainder.
    function automatic t_div_result predict_division(t_operand num, t_operand den);
        t_div_result r;
        if (den == '0) begin
            r.quotient     = '0;
            r.remainder    = num;
            r.zero_divisor = 1'b1;
        end else begin
            r.quotient     = num / den;
            r.remainder    = num % den;
            r.zero_divisor = 1'b0;
        end
        return r;
    endfunction

    function automatic int send_idle_pct(t_phase p);
        case (p)
            PH_SEND_IDLE: return 71;
            PH_BOTH_IDLE: return 31;
            default:      return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(t_phase p);
        case (p)
            PH_RECV_STALL: return 71;
            PH_BOTH_IDLE:  return 31;
            default:       return 0;
        endcase
    endfunction

    // Full-width random value, often shortened so that all magnitudes show up.
    function automatic t_operand rand_operand();
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(1) == 1) begin
            r = r >> $urandom_range(62);
        end
        return r[W-1:0];
    endfunction

    task automatic add_division(t_operand num, t_operand den);
        t_div_operands op;
        op.dividend = num;
        op.divisor  = den;
        pending_ops.push_back(op);
    endtask

    task automatic run_phase(t_phase p, int count);
        t_operand num;
        t_operand den;
        @(negedge i_clk);
        phase = p;
        for (int k = 0; k < count; k++) begin
            num = ($urandom_range(15) == 0) ? OP_MAX : rand_operand();
            case ($urandom_range(9))
                0:       den = '0;
                1:       den = t_operand'($urandom_range(1, 16));
                2:       den = num;
                3:       den = num + OP_ONE;
                4:       den = OP_MAX;
                5, 6:    den = rand_operand();
                default: den = t_operand'({$urandom, $urandom});
            endcase
            add_division(num, den);
        end
        while (pending_ops.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
    endtask

    // Input side: a new operand pair is presented only once the previous one has
    // completed its transfer, so valid and payload stay stable while waiting.
    always @(posedge i_clk) begin
        t_div_operands next_op;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_division(i_dividend, i_divisor));
                ops_accepted++;
            end
            if (i_in_valid && !o_in_ready) begin
                input_stall_cycles++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct(phase)) begin
                    next_op = pending_ops.pop_front();
                    i_dividend <= next_op.dividend;
                    i_divisor  <= next_op.divisor;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output ready. In the backpressure phase it is held low for a long count
    // first, so the pipeline fills and the unit has to stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_cnt    <= 0;
        end else if (phase == PH_BACKPRESSURE && hold_cnt < HOLD_LEN) begin
            i_out_ready <= 1'b0;
            hold_cnt    <= hold_cnt + 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct(phase));
        end
    end

    always @(posedge i_clk) begin
        t_div_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result: quotient %h remainder %h zero_divisor %b",
                             o_quotient, o_remainder, o_zero_divisor);
                end
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.zero_divisor) begin
                    zero_div_results++;
                end
                if (o_quotient !== want.quotient || o_remainder !== want.remainder ||
                    o_zero_divisor !== want.zero_divisor) begin
                    failures++;
                    if (failures <= 10) begin
                        $display({"result %0d mismatch: expected q %h r %h z %b,",
                                  " got q %h r %h z %b"},
                                 results_checked, want.quotient, want.remainder,
                                 want.zero_divisor, o_quotient, o_remainder, o_zero_divisor);
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("unsigned_divide_remainder_unit_tb: errors");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes, zero divisors, divisor above or equal to dividend, top bits set.
        add_division('0, '0);
        add_division(OP_MAX, '0);
        add_division(t_operand'(12345), '0);
        add_division('0, OP_ONE);
        add_division(OP_MAX, OP_ONE);
        add_division(OP_MAX, OP_MAX);
        add_division(OP_MAX, OP_MAX - OP_ONE);
        add_division(OP_MAX - OP_ONE, OP_MAX);
        add_division(OP_ONE, OP_MAX);
        add_division(OP_MAX, t_operand'(2));
        add_division(OP_MAX, t_operand'(3));
        add_division(OP_MAX, OP_ONE << (W - 1));
        add_division(OP_ONE << (W - 1), (OP_ONE << (W - 1)) - OP_ONE);
        add_division(OP_ONE << (W - 1), OP_ONE);
        add_division(t_operand'(7), t_operand'(3));
        add_division(t_operand'(100), t_operand'(10));
        add_division(t_operand'(5), t_operand'(7));
        add_division(t_operand'({(W + 1) / 2{2'b01}}), t_operand'({(W + 1) / 2{2'b10}}));
        add_division(t_operand'({(W + 1) / 2{2'b10}}), t_operand'({(W + 1) / 2{2'b01}}));
        add_division(OP_MAX, OP_ONE << 31);
        add_division(OP_ONE << 32, OP_ONE << 32);
        while (pending_ops.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end

        run_phase(PH_STREAM, 250);
        run_phase(PH_SEND_IDLE, 220);
        run_phase(PH_RECV_STALL, 220);
        run_phase(PH_BOTH_IDLE, 220);
        run_phase(PH_BACKPRESSURE, 220);

        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d divisions (%0d by zero), %0d results checked, %0d mismatches.",
                 ops_accepted, zero_div_results, results_checked, failures);
        $display("Flow control: gaps and stalls on both sides, input held off %0d cycles.",
                 input_stall_cycles);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("unsigned_divide_remainder_unit_tb: clean");
        end else begin
            $display("unsigned_divide_remainder_unit_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
